/* hw/rtl/tlt_pkg.sv */
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, token kind codes and character helpers for the tokenizer.
// ----------------------------------------------------------------------------
package tlt_pkg;

	// width of the saturating line counter
	localparam int LINE_WIDTH = 16;

	// number of results one character can cause
	localparam int MAX_RES = 3;

	// token kinds
	localparam logic [3:0] KIND_BYTE    = 4'd0;
	localparam logic [3:0] KIND_ID      = 4'd1;
	localparam logic [3:0] KIND_STR     = 4'd2;
	localparam logic [3:0] KIND_INT     = 4'd3;
	localparam logic [3:0] KIND_PLUS    = 4'd4;
	localparam logic [3:0] KIND_STAR    = 4'd5;
	localparam logic [3:0] KIND_LEFTSQ  = 4'd6;
	localparam logic [3:0] KIND_RIGHTSQ = 4'd7;
	localparam logic [3:0] KIND_PRINT   = 4'd8;
	localparam logic [3:0] KIND_SET     = 4'd9;
	localparam logic [3:0] KIND_SC      = 4'd10;
	localparam logic [3:0] KIND_LPAREN  = 4'd11;
	localparam logic [3:0] KIND_RPAREN  = 4'd12;
	localparam logic [3:0] KIND_DONE    = 4'd13;
	localparam logic [3:0] KIND_ERR     = 4'd14;

	// keyword match position that marks a mismatch
	localparam logic [2:0] MATCH_MISS = 3'd7;
	localparam logic [2:0] PRINT_LEN  = 3'd5;
	localparam logic [2:0] SET_LEN    = 3'd3;

	// characters with special meaning
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_LEFTSQ  = 8'h5B;
	localparam logic [7:0] CH_RIGHTSQ = 8'h5D;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// all results caused by one character
	typedef struct packed {
		logic [1:0]                 count;
		logic [MAX_RES-1:0][3:0]    kind;
		logic [MAX_RES-1:0][7:0]    char_val;
		logic [15:0]                line;
	} bundle_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// step the "print" prefix match by one letter
	function automatic logic [2:0] adv_print(input logic [2:0] pos, input logic [7:0] c);
		logic [7:0] want;
		want = 8'h00;
		case (pos)
			3'd0: want = 8'h70;
			3'd1: want = 8'h72;
			3'd2: want = 8'h69;
			3'd3: want = 8'h6E;
			3'd4: want = 8'h74;
			default: want = 8'h00;
		endcase
		if (pos < PRINT_LEN && want == c) begin
			return pos + 3'd1;
		end
		return MATCH_MISS;
	endfunction

	// step the "set" prefix match by one letter
	function automatic logic [2:0] adv_set(input logic [2:0] pos, input logic [7:0] c);
		logic [7:0] want;
		want = 8'h00;
		case (pos)
			3'd0: want = 8'h73;
			3'd1: want = 8'h65;
			3'd2: want = 8'h74;
			default: want = 8'h00;
		endcase
		if (pos < SET_LEN && want == c) begin
			return pos + 3'd1;
		end
		return MATCH_MISS;
	endfunction

endpackage

/* hw/rtl/toy_language_tokenizer.sv */
// ----------------------------------------------------------------------------
// toy_language_tokenizer
// Streaming tokenizer: characters in, lexeme bytes and token kinds out.
// ----------------------------------------------------------------------------
// A character transfer is taken every cycle while the output keeps up. Each
// character is decoded in the cycle it arrives into zero to three results,
// which go as one bundle into a two-entry queue; when the queue was empty, the
// first result is offered on the token port the cycle after the transfer. The
// token port moves one result per transfer, so a character that causes several
// results holds the port for one transfer per result, while characters with no
// result, such as spaces and comment text, cost nothing at the output. New
// characters are taken while earlier results are still being sent.
// The input stalls only while both queue entries are occupied.
module toy_language_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_input,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  result_kind,
	output logic [7:0]  lexeme_char,
	output logic [15:0] line_number,
	output logic        last_of_run
);

	tlt_pkg::bundle_t bundle;
	logic             accept;
	logic             full;

	assign char_stall = full;
	assign accept     = char_valid && !full;

	// character decode and lexer state
	tlt_lexer u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.bundle       (bundle)
	);

	// result queue and serializer
	tlt_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept && bundle.count != 2'd0),
		.push_bundle (bundle),
		.full        (full),
		.tok_valid   (tok_valid),
		.tok_stall   (tok_stall),
		.result_kind (result_kind),
		.lexeme_char (lexeme_char),
		.line_number (line_number),
		.last_of_run (last_of_run)
	);

endmodule

/* hw/rtl/tlt_lexer.sv */
// ----------------------------------------------------------------------------
// tlt_lexer
// Lexer state and the per-character decode into a bundle of up to three results.
// ----------------------------------------------------------------------------
module tlt_lexer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       char_byte,
	input  logic             end_of_input,
	output tlt_pkg::bundle_t bundle
);

	typedef enum logic [2:0] {
		MODE_BEGIN,
		MODE_ID,
		MODE_STR,
		MODE_INT,
		MODE_COMMENT,
		MODE_SLASH
	} mode_t;

	mode_t                          mode_q, mode_d;
	logic [2:0]                     pmatch_q, pmatch_d;
	logic [2:0]                     smatch_q, smatch_d;
	logic [tlt_pkg::LINE_WIDTH-1:0] line_q, line_d;
	logic [tlt_pkg::LINE_WIDTH+15:0] line_ext;

	// low 16 bits of the line count, zero-extended when the counter is narrow
	assign line_ext = {16'd0, line_q};

	// decode one character against the current mode
	always_comb begin
		logic [1:0] n;
		logic       rerun;
		n = 2'd0;
		rerun = 1'b0;
		mode_d = mode_q;
		pmatch_d = pmatch_q;
		smatch_d = smatch_q;
		line_d = line_q;
		bundle.kind = '0;
		bundle.char_val = '0;
		bundle.line = line_ext[15:0];

		if (end_of_input) begin
			case (mode_q)
				MODE_ID: begin
					bundle.kind[n] = tlt_pkg::KIND_ID;
					n = n + 2'd1;
				end
				MODE_INT: begin
					bundle.kind[n] = tlt_pkg::KIND_INT;
					n = n + 2'd1;
				end
				MODE_STR, MODE_COMMENT, MODE_SLASH: begin
					bundle.kind[n] = tlt_pkg::KIND_ERR;
					n = n + 2'd1;
				end
				default: ;
			endcase
			bundle.kind[n] = tlt_pkg::KIND_DONE;
			n = n + 2'd1;
			mode_d = MODE_BEGIN;
			pmatch_d = 3'd0;
			smatch_d = 3'd0;
		end else begin
			// mode-specific handling
			case (mode_q)
				MODE_ID: begin
					if (tlt_pkg::is_letter(char_byte)) begin
						bundle.kind[n] = tlt_pkg::KIND_BYTE;
						bundle.char_val[n] = char_byte;
						n = n + 2'd1;
						pmatch_d = tlt_pkg::adv_print(pmatch_q, char_byte);
						smatch_d = tlt_pkg::adv_set(smatch_q, char_byte);
					end else begin
						if (pmatch_q == tlt_pkg::PRINT_LEN) begin
							bundle.kind[n] = tlt_pkg::KIND_PRINT;
						end else if (smatch_q == tlt_pkg::SET_LEN) begin
							bundle.kind[n] = tlt_pkg::KIND_SET;
						end else begin
							bundle.kind[n] = tlt_pkg::KIND_ID;
						end
						n = n + 2'd1;
						mode_d = MODE_BEGIN;
						rerun = 1'b1;
					end
				end
				MODE_STR: begin
					if (char_byte == tlt_pkg::CH_NEWLINE) begin
						bundle.kind[n] = tlt_pkg::KIND_ERR;
						n = n + 2'd1;
						mode_d = MODE_BEGIN;
					end else if (char_byte == tlt_pkg::CH_QUOTE) begin
						bundle.kind[n] = tlt_pkg::KIND_STR;
						n = n + 2'd1;
						mode_d = MODE_BEGIN;
					end else begin
						bundle.kind[n] = tlt_pkg::KIND_BYTE;
						bundle.char_val[n] = char_byte;
						n = n + 2'd1;
					end
				end
				MODE_INT: begin
					if (tlt_pkg::is_digit(char_byte)) begin
						bundle.kind[n] = tlt_pkg::KIND_BYTE;
						bundle.char_val[n] = char_byte;
						n = n + 2'd1;
					end else begin
						bundle.kind[n] = tlt_pkg::KIND_INT;
						n = n + 2'd1;
						mode_d = MODE_BEGIN;
						rerun = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (char_byte == tlt_pkg::CH_NEWLINE) begin
						mode_d = MODE_BEGIN;
					end
				end
				MODE_SLASH: begin
					if (char_byte == tlt_pkg::CH_SLASH) begin
						mode_d = MODE_COMMENT;
					end else begin
						bundle.kind[n] = tlt_pkg::KIND_ERR;
						n = n + 2'd1;
						mode_d = MODE_BEGIN;
						rerun = 1'b1;
					end
				end
				default: begin
					mode_d = MODE_BEGIN;
					rerun = 1'b1;
				end
			endcase

			// begin-state handling, also for a character that ended a run
			if (rerun) begin
				if (char_byte == tlt_pkg::CH_NEWLINE && line_q != '1) begin
					line_d = line_q + 1'b1;
				end
				if (tlt_pkg::is_space(char_byte)) begin
					// skipped
				end else if (char_byte == tlt_pkg::CH_QUOTE) begin
					mode_d = MODE_STR;
				end else begin
					bundle.kind[n] = tlt_pkg::KIND_BYTE;
					bundle.char_val[n] = char_byte;
					n = n + 2'd1;
					if (tlt_pkg::is_letter(char_byte)) begin
						mode_d = MODE_ID;
						pmatch_d = tlt_pkg::adv_print(3'd0, char_byte);
						smatch_d = tlt_pkg::adv_set(3'd0, char_byte);
					end else if (tlt_pkg::is_digit(char_byte)) begin
						mode_d = MODE_INT;
					end else begin
						case (char_byte)
							tlt_pkg::CH_SLASH:   mode_d = MODE_SLASH;
							tlt_pkg::CH_PLUS:    bundle.kind[n] = tlt_pkg::KIND_PLUS;
							tlt_pkg::CH_STAR:    bundle.kind[n] = tlt_pkg::KIND_STAR;
							tlt_pkg::CH_LEFTSQ:  bundle.kind[n] = tlt_pkg::KIND_LEFTSQ;
							tlt_pkg::CH_RIGHTSQ: bundle.kind[n] = tlt_pkg::KIND_RIGHTSQ;
							tlt_pkg::CH_LPAREN:  bundle.kind[n] = tlt_pkg::KIND_LPAREN;
							tlt_pkg::CH_RPAREN:  bundle.kind[n] = tlt_pkg::KIND_RPAREN;
							tlt_pkg::CH_SEMI:    bundle.kind[n] = tlt_pkg::KIND_SC;
							default:             bundle.kind[n] = tlt_pkg::KIND_ERR;
						endcase
						if (char_byte != tlt_pkg::CH_SLASH) begin
							n = n + 2'd1;
						end
					end
				end
			end
		end
		bundle.count = n;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BEGIN;
			pmatch_q <= 3'd0;
			smatch_q <= 3'd0;
			line_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pmatch_q <= pmatch_d;
			smatch_q <= smatch_d;
			line_q <= line_d;
		end
	end

endmodule

/* hw/rtl/tlt_outq.sv */
// ----------------------------------------------------------------------------
// tlt_outq
// Two-entry queue of result bundles, drained one result per transfer.
// ----------------------------------------------------------------------------
module tlt_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tlt_pkg::bundle_t push_bundle,
	output logic             full,
	output logic             tok_valid,
	input  logic             tok_stall,
	output logic [3:0]       result_kind,
	output logic [7:0]       lexeme_char,
	output logic [15:0]      line_number,
	output logic             last_of_run
);

	tlt_pkg::bundle_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic [1:0]       idx_q;
	logic             take;
	logic             pop;
	tlt_pkg::bundle_t head;

	assign head        = entry_q[rd_ptr_q];
	assign full        = fill_q == 2'd2;
	assign tok_valid   = fill_q != 2'd0;
	assign result_kind = head.kind[idx_q];
	assign lexeme_char = head.char_val[idx_q];
	assign line_number = head.line;
	assign last_of_run = idx_q == head.count - 2'd1;
	assign take        = tok_valid && !tok_stall;
	assign pop         = take && last_of_run;

	// bundle storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_bundle;
		end
	end

	// pointers, fill level and position within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
			idx_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q <= 2'd0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// fill level stays within the queue depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("bundle queue fill level out of range");

	// no bundle is written over
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full bundle queue");

	// the head bundle always holds at least one result and the position is inside it
	a_head_sane: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (head.count != 2'd0 && idx_q < head.count))
		else $error("head bundle position out of range");

	// a stalled result holds its position in the bundle
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok_stall) |=> $stable(idx_q))
		else $error("result position moved during a stall");

endmodule
